// File: src/rne_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rne_pkg: shared types and constants of the Roman numeral encoder
// Status codes, symbol codes, the digit descriptor passed from front to back,
// and the small per-digit symbol tables.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int unsigned VALUE_W  = 12;
  localparam int unsigned SYM_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned NDIGITS  = 4;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTHING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  // symbol code carried by status-only results
  localparam logic [SYM_W-1:0] SYM_I = 3'd0;

  // symbol offset within a decade: unit, five, next unit
  localparam logic [1:0] OFF_ONE  = 2'd0;
  localparam logic [1:0] OFF_FIVE = 2'd1;
  localparam logic [1:0] OFF_TEN  = 2'd2;

  typedef logic [DIGIT_W-1:0] digit_t;

  // one classified item: status plus decimal digits, index 0 = ones
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    digit_t [NDIGITS-1:0]      digits;
  } desc_t;

  // number of symbols a decimal digit expands to
  function automatic logic [2:0] digit_len(input digit_t d);
    logic [2:0] n;
    case (d)
      4'd1, 4'd5:             n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
      4'd3, 4'd7:             n = 3'd3;
      4'd8:                   n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  // symbol offset of the j-th symbol of digit d
  function automatic logic [1:0] sym_off(input digit_t d, input logic [1:0] j);
    logic [1:0] o;
    case (d)
      4'd4:             o = (j == 2'd0) ? OFF_ONE : OFF_FIVE;
      4'd5:             o = OFF_FIVE;
      4'd6, 4'd7, 4'd8: o = (j == 2'd0) ? OFF_FIVE : OFF_ONE;
      4'd9:             o = (j == 2'd0) ? OFF_ONE : OFF_TEN;
      default:          o = OFF_ONE;
    endcase
    return o;
  endfunction

  // decade weight used at each split step
  function automatic logic [9:0] step_weight(input logic [1:0] step);
    logic [9:0] w;
    case (step)
      2'd0:    w = 10'd1000;
      2'd1:    w = 10'd100;
      default: w = 10'd10;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: src/rne_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rne_front: input stage
// Accepts a value, classifies it (zero, out of range, valid) and splits a
// valid value into decimal digits, one decade per cycle.
// ----------------------------------------------------------------------------
module rne_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [rne_pkg::VALUE_W-1:0]  in_value,
  output rne_pkg::desc_t                    q_wdata,
  output logic                              q_push,
  input  wire logic                         q_full
);
  import rne_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_SPLIT = 3'b010,
    F_PUSH  = 3'b100
  } fstate_t;

  fstate_t                 state_r, state_nxt;
  logic [1:0]              step_r, step_nxt;
  logic [VALUE_W-1:0]      rem_r, rem_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;
  digit_t [NDIGITS-1:1]    hi_r, hi_nxt;

  logic                    accept;
  logic [STATUS_W-1:0]     in_class;
  logic [9:0]              weight;
  digit_t                  dig;
  logic [13:0]             sub;
  logic [1:0]              dig_idx;

  assign full   = (state_r != F_IDLE);
  assign accept = push && !full;

  // classify the incoming value
  always_comb begin
    if (in_value == '0) begin
      in_class = ST_NOTHING;
    end else if (in_value > MAX_VALUE) begin
      in_class = ST_RANGE;
    end else begin
      in_class = ST_OK;
    end
  end

  // one decade: largest multiple of the weight not above the remainder
  always_comb begin
    weight = step_weight(step_r);
    dig    = '0;
    sub    = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, rem_r} >= 14'(k) * {4'b0000, weight}) begin
        dig = DIGIT_W'(k);
        sub = 14'(k) * {4'b0000, weight};
      end
    end
  end

  assign dig_idx = 2'd3 - step_r;

  // next-state logic
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    rem_nxt    = rem_r;
    status_nxt = status_r;
    hi_nxt     = hi_r;
    q_push     = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          rem_nxt    = in_value;
          status_nxt = in_class;
          step_nxt   = 2'd0;
          state_nxt  = (in_class == ST_OK) ? F_SPLIT : F_PUSH;
        end
      end
      F_SPLIT: begin
        hi_nxt[dig_idx] = dig;
        rem_nxt         = rem_r - sub[VALUE_W-1:0];
        step_nxt        = step_r + 2'd1;
        if (step_r == 2'd2) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // descriptor to the queue; ones digit is what remains
  always_comb begin
    q_wdata.status    = status_r;
    q_wdata.digits[3] = hi_r[3];
    q_wdata.digits[2] = hi_r[2];
    q_wdata.digits[1] = hi_r[1];
    q_wdata.digits[0] = rem_r[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_r   <= step_nxt;
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    hi_r     <= hi_nxt;
  end

endmodule
`default_nettype wire

// File: src/rne_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rne_queue: two-entry descriptor queue
// Decouples digit splitting from symbol emission.
// ----------------------------------------------------------------------------
module rne_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire rne_pkg::desc_t wr_data,
  output logic                q_full,
  input  wire logic           rd_en,
  output rne_pkg::desc_t      rd_data,
  output logic                q_empty
);
  import rne_pkg::*;

  desc_t       slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_wr, do_rd;

  assign q_full  = (count_r == 2'd2);
  assign q_empty = (count_r == 2'd0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/rne_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rne_back: symbol sequencer
// Walks the digits of a descriptor from thousands down and emits one symbol
// per beat into the output register, marking the final beat of each run.
// ----------------------------------------------------------------------------
module rne_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rne_pkg::desc_t                rd_data,
  input  wire logic                          q_empty,
  output logic                               rd_en,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [rne_pkg::SYM_W-1:0]          out_symbol,
  output logic                               out_last,
  output logic [rne_pkg::STATUS_W-1:0]       out_status
);
  import rne_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } bstate_t;

  bstate_t               state_r, state_nxt;
  digit_t [NDIGITS-1:0]  digits_r, digits_nxt;
  logic [1:0]            pos_r, pos_nxt;
  logic [1:0]            j_r, j_nxt;

  logic                  valid_r, valid_nxt;
  logic [SYM_W-1:0]      sym_r, sym_nxt;
  logic                  last_r, last_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;

  logic                  adv;
  digit_t                cur_d;
  logic [2:0]            len;
  logic                  lower_zero;
  logic                  digit_end;
  logic [SYM_W-1:0]      cur_sym;

  assign empty      = !valid_r;
  assign out_symbol = sym_r;
  assign out_last   = last_r;
  assign out_status = status_r;

  // output register can take a beat
  assign adv = !valid_r || pop;

  // current digit and symbol
  always_comb begin
    cur_d      = digits_r[pos_r];
    len        = digit_len(cur_d);
    digit_end  = ({1'b0, j_r} == len - 3'd1);
    cur_sym    = {pos_r, 1'b0} + SYM_W'(sym_off(cur_d, j_r));
    lower_zero = 1'b1;
    for (int i = 0; i < NDIGITS; i++) begin
      if (2'(i) < pos_r && digits_r[i] != '0) begin
        lower_zero = 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    digits_nxt = digits_r;
    pos_nxt    = pos_r;
    j_nxt      = j_r;
    rd_en      = 1'b0;
    valid_nxt  = valid_r && !pop;
    sym_nxt    = sym_r;
    last_nxt   = last_r;
    status_nxt = status_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty && adv) begin
          rd_en = 1'b1;
          if (rd_data.status != ST_OK) begin
            valid_nxt  = 1'b1;
            sym_nxt    = SYM_I;
            last_nxt   = 1'b1;
            status_nxt = rd_data.status;
          end else begin
            digits_nxt = rd_data.digits;
            pos_nxt    = 2'd3;
            j_nxt      = 2'd0;
            state_nxt  = B_RUN;
          end
        end
      end
      B_RUN: begin
        if (cur_d == '0) begin
          pos_nxt = pos_r - 2'd1;
        end else if (adv) begin
          valid_nxt  = 1'b1;
          sym_nxt    = cur_sym;
          last_nxt   = digit_end && lower_zero;
          status_nxt = ST_OK;
          if (digit_end && lower_zero) begin
            state_nxt = B_IDLE;
          end else if (digit_end) begin
            pos_nxt = pos_r - 2'd1;
            j_nxt   = 2'd0;
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    digits_r <= digits_nxt;
    pos_r    <= pos_nxt;
    j_r      <= j_nxt;
    sym_r    <= sym_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
  end

endmodule
`default_nettype wire

// File: src/roman_numeral_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A valid value passes the front's split and push states, the queue, the sequencer load
// and the output register; zero and out-of-range values skip the split and the load.
// The symbol sequencer loads a descriptor, then emits one symbol per beat while the
// output register can take it, skipping each zero decade above the last nonzero digit;
// the front takes one value at a time and is full until it has pushed its descriptor.
// Reset (synchronous, rst_n low) empties the queue and output register and idles both FSMs.
// ----------------------------------------------------------------------------
// roman_numeral_encoder_unit: integer to Roman numeral symbol stream
// Front splits values into digits, a two-entry queue decouples it from the
// back, which emits one symbol code per beat with a last mark.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [rne_pkg::VALUE_W-1:0]   in_value,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [rne_pkg::SYM_W-1:0]          out_symbol,
  output logic                               out_last,
  output logic [rne_pkg::STATUS_W-1:0]       out_status
);
  import rne_pkg::*;

  desc_t q_wdata, q_rdata;
  logic  q_push, q_full, q_pop, q_empty;

  // classify and split
  rne_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_value (in_value),
    .q_wdata  (q_wdata),
    .q_push   (q_push),
    .q_full   (q_full)
  );

  // descriptor queue
  rne_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  // symbol emission
  rne_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_data    (q_rdata),
    .q_empty    (q_empty),
    .rd_en      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule
`default_nettype wire
